[rtl/core/lobm_pkg.sv]
// Package with the word types, result kinds and book size of the order book matcher.
package lobm_pkg;

  localparam int BookDepth = 32;
  localparam int IdxW = $clog2(BookDepth);

  localparam logic [0:0] FUNC_SUBMIT = 1'b0;
  localparam logic [0:0] FUNC_CANCEL = 1'b1;

  localparam logic [2:0] KIND_FILL      = 3'd0;
  localparam logic [2:0] KIND_ACK       = 3'd1;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd2;
  localparam logic [2:0] KIND_DUP       = 3'd3;
  localparam logic [2:0] KIND_BAD_QTY   = 3'd4;
  localparam logic [2:0] KIND_FULL      = 3'd5;

  typedef struct packed {
    logic [0:0]         func;
    logic [31:0]        order_id;
    logic               buy_side;
    logic [15:0]        limit_price;
    logic signed [15:0] order_qty;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] taker_id;
    logic [31:0] maker_id;
    logic [15:0] trade_price;
    logic [14:0] trade_qty;
    logic        last;
  } out_word_t;

endpackage

[rtl/core/limit_order_book_matcher.sv]
// Top level of the price-time priority limit order book matcher.
//
//   channel | ports                  | handshake
//   input   | start, busy, in_word   | taken when start && !busy
//   result  | out_strobe, out_word   | one-cycle strobe per word, no stall
//
// A request is taken in idle; busy then stays high until the cycle after its
// final word. An id scan checks all BookDepth slots, one per cycle, through one
// shared compare unit. A submit then alternates a best-entry scan of all slots
// with a fill of the best crossing entry until filled or none crosses; any
// remainder rests in a free slot, or the result is full. A cancel or reject ends
// after the id scan. Reset empties the book at once; the receiver cannot stall.
module limit_order_book_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  lobm_pkg::in_word_t  in_word,
  output logic                busy,
  output logic                out_strobe,
  output lobm_pkg::out_word_t out_word
);
  import lobm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_IDSCN = 6'b000010,
    ST_BEST  = 6'b000100,
    ST_FILL  = 6'b001000,
    ST_FREE  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [BookDepth-1:0] valid_r, valid_nxt;
  logic                 e_buy_r   [BookDepth];
  logic [15:0]          e_price_r [BookDepth];
  logic [14:0]          e_rem_r   [BookDepth];
  logic [31:0]          e_id_r    [BookDepth];
  logic [31:0]          e_arr_r   [BookDepth];
  logic [31:0]          arr_cnt_r, arr_cnt_nxt;

  in_word_t             req_r;
  logic [14:0]          left_r, left_nxt;
  logic [IdxW:0]        scan_r, scan_nxt;
  logic                 found_r, found_nxt;
  logic [IdxW-1:0]      hit_r, hit_nxt;
  logic                 out_strobe_nxt;
  out_word_t            out_nxt;

  logic [IdxW-1:0]      si;
  logic                 cand, better;
  logic [31:0]          arr_diff;
  logic [14:0]          traded;
  logic                 wr_en;
  logic                 upd_en;
  logic [14:0]          upd_rem;

  assign si       = scan_r[IdxW-1:0];
  assign arr_diff = e_arr_r[si] - e_arr_r[hit_r];
  assign cand = valid_r[si] && (e_buy_r[si] != req_r.buy_side) &&
                (req_r.buy_side ? (e_price_r[si] <= req_r.limit_price)
                                : (e_price_r[si] >= req_r.limit_price));
  always_comb begin
    if (e_price_r[si] != e_price_r[hit_r]) begin
      better = req_r.buy_side ? (e_price_r[si] < e_price_r[hit_r])
                              : (e_price_r[si] > e_price_r[hit_r]);
    end else begin
      better = arr_diff[31];
    end
  end
  assign traded = (left_r < e_rem_r[hit_r]) ? left_r : e_rem_r[hit_r];

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    arr_cnt_nxt    = arr_cnt_r;
    left_nxt       = left_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    out_nxt.taker_id = req_r.order_id;
    out_nxt.last   = 1'b1;
    wr_en          = 1'b0;
    upd_en         = 1'b0;
    upd_rem        = e_rem_r[hit_r] - traded;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_IDSCN;
          scan_nxt  = '0;
          found_nxt = 1'b0;
          hit_nxt   = '0;
        end
      end
      ST_IDSCN: begin
        if (!found_r && valid_r[si] && e_id_r[si] == req_r.order_id) begin
          found_nxt = 1'b1;
          hit_nxt   = si;
        end
        scan_nxt = scan_r + 1'b1;
        if (scan_r == (IdxW+1)'(BookDepth - 1)) begin
          state_nxt = ST_DONE;
          out_strobe_nxt = 1'b1;
          if (req_r.func == FUNC_CANCEL) begin
            if (found_nxt) begin
              out_nxt.kind = KIND_ACK;
              valid_nxt[hit_nxt] = 1'b0;
            end else begin
              out_nxt.kind = KIND_NOT_FOUND;
            end
          end else if (found_nxt) begin
            out_nxt.kind = KIND_DUP;
          end else if (req_r.order_qty <= 0) begin
            out_nxt.kind = KIND_BAD_QTY;
          end else begin
            out_strobe_nxt = 1'b0;
            left_nxt  = req_r.order_qty[14:0];
            state_nxt = ST_BEST;
            scan_nxt  = '0;
            found_nxt = 1'b0;
          end
        end
      end
      ST_BEST: begin
        if (cand && (!found_r || better)) begin
          found_nxt = 1'b1;
          hit_nxt   = si;
        end
        scan_nxt = scan_r + 1'b1;
        if (scan_r == (IdxW+1)'(BookDepth - 1)) begin
          state_nxt = found_nxt ? ST_FILL : ST_FREE;
          scan_nxt  = '0;
        end
      end
      ST_FILL: begin
        out_strobe_nxt      = 1'b1;
        out_nxt.kind        = KIND_FILL;
        out_nxt.maker_id    = e_id_r[hit_r];
        out_nxt.trade_price = e_price_r[hit_r];
        out_nxt.trade_qty   = traded;
        out_nxt.last        = 1'b0;
        upd_en   = 1'b1;
        left_nxt = left_r - traded;
        if (upd_rem == '0) valid_nxt[hit_r] = 1'b0;
        found_nxt = 1'b0;
        scan_nxt  = '0;
        state_nxt = (left_nxt == '0) ? ST_FREE : ST_BEST;
      end
      ST_FREE: begin
        if (left_r == '0) begin
          out_strobe_nxt = 1'b1;
          out_nxt.kind   = KIND_ACK;
          state_nxt      = ST_DONE;
        end else if (!valid_r[si]) begin
          wr_en = 1'b1;
          valid_nxt[si] = 1'b1;
          arr_cnt_nxt = arr_cnt_r + 32'd1;
          out_strobe_nxt = 1'b1;
          out_nxt.kind   = KIND_ACK;
          state_nxt      = ST_DONE;
        end else if (scan_r == (IdxW+1)'(BookDepth - 1)) begin
          out_strobe_nxt = 1'b1;
          out_nxt.kind   = KIND_FULL;
          state_nxt      = ST_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      valid_r    <= '0;
      arr_cnt_r  <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      arr_cnt_r  <= arr_cnt_nxt;
      out_strobe <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) req_r <= in_word;
    left_r   <= left_nxt;
    scan_r   <= scan_nxt;
    found_r  <= found_nxt;
    hit_r    <= hit_nxt;
    out_word <= out_nxt;
    if (upd_en) e_rem_r[hit_r] <= upd_rem;
    if (wr_en) begin
      e_buy_r[si]   <= req_r.buy_side;
      e_price_r[si] <= req_r.limit_price;
      e_rem_r[si]   <= left_r;
      e_id_r[si]    <= req_r.order_id;
      e_arr_r[si]   <= arr_cnt_r;
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  a_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.kind == KIND_FILL) |-> !out_word.last)
    else $error("fill word marked last");
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.last) |-> state_r == ST_DONE)
    else $error("final word outside done state");
  a_fill_qty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.kind == KIND_FILL) |-> out_word.trade_qty != '0)
    else $error("empty fill");
  a_rest_counts: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> arr_cnt_r == $past(arr_cnt_r) + 32'd1)
    else $error("arrival counter missed a rest");
`endif

endmodule
